@@ hdl/gbe_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the bitmap engine.
`timescale 1ns / 1ps

package gbe_pkg;

  localparam int MAX_BITS = 4096;
  localparam int WORD_W   = 32;
  localparam int WORDS    = MAX_BITS / WORD_W;
  localparam int WIDX_W   = $clog2(WORDS);
  localparam int BIDX_W   = $clog2(WORD_W);
  localparam int OFF_W    = 12;
  localparam int SIZE_W   = 13;
  localparam int REQ_W    = 3;
  localparam int ST_W     = 2;
  localparam int PC_W     = BIDX_W + 1;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_USED_W  = 1 + 2 * SIZE_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_INIT      = 3'd0,
    REQ_SET_BIT   = 3'd1,
    REQ_SET_RANGE = 3'd2,
    REQ_READ_BIT  = 3'd3,
    REQ_COUNT     = 3'd4
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_CAP   = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_RSTCLR,
    S_IDLE,
    S_EXEC,
    S_INITCLR,
    S_FILL,
    S_RDWAIT,
    S_RDCAP,
    S_CNT,
    S_CNTEND,
    S_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic clr_wr;
    logic fill_wr;
    logic widx_inc;
    logic cnt_rd;
    logic rd_cap;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic ok;
    logic zero_len;
    logic widx_max;
    logic widx_at_hi;
    logic out_free;
  } dp_stat_t;

endpackage

@@ hdl/growable_bitmap_engine_top.sv @@
// Top level of the growable bitmap engine: stream ports, sequencer and datapath.
`timescale 1ns / 1ps
// Usage:
//  Requests enter on the s_axis channel: s_axis_tuser carries the request kind
//  (init, set bit, set range, read bit, count), s_axis_tdata the offsets, run
//  length and write value. Each request gives exactly one result word on m_axis:
//  m_axis_tuser is the status, m_axis_tdata the read bit, count and logical size.
//  The store is 128 words of 32 bits in a single memory; range set and count
//  walk it one word per cycle.
//  Each request is accepted, checked, and then worked: set range and count walk
//  the spanned words, init clears the whole store, set bit writes its one word
//  and read bit reads it; rejected or unused requests and zero-length ranges go
//  straight to the result load. One request is in work at a time; the next is
//  taken only once the result of the last one has been loaded.
//  After reset the store is cleared word by word with s_axis_tready low.
//  The result sits in an output register; a new request is taken while it waits,
//  and that request's result is held back until m_axis_tready takes the old one.

module growable_bitmap_engine_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // bit_offset[11:0], end_offset[23:12], run_length[36:24], write_bit[37], zero pad
  input  logic [gbe_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // req_type[2:0]
  input  logic [gbe_pkg::REQ_W-1:0]          s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // read_value[0], ones_count[13:1], logical_size[26:14], zero pad
  output logic [gbe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // status[1:0]
  output logic [gbe_pkg::ST_W-1:0]           m_axis_tuser
);

  gbe_pkg::dp_cmd_t                 cmd;
  gbe_pkg::dp_stat_t                stat;
  gbe_pkg::status_t                 out_status;
  logic                             out_read_value;
  logic [gbe_pkg::SIZE_W-1:0]       out_ones_count;
  logic [gbe_pkg::SIZE_W-1:0]       out_logical_size;

  gbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbe_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .in_req           (s_axis_tuser),
    .in_off           (s_axis_tdata[11:0]),
    .in_end           (s_axis_tdata[23:12]),
    .in_len           (s_axis_tdata[36:24]),
    .in_wbit          (s_axis_tdata[37]),
    .cmd              (cmd),
    .stat             (stat),
    .out_ready        (m_axis_tready),
    .out_valid        (m_axis_tvalid),
    .out_status       (out_status),
    .out_read_value   (out_read_value),
    .out_ones_count   (out_ones_count),
    .out_logical_size (out_logical_size)
  );

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {{(gbe_pkg::OUT_TDATA_W - gbe_pkg::OUT_USED_W){1'b0}},
                         out_logical_size, out_ones_count, out_read_value};

  a_count_within_size: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_ones_count <= out_logical_size)
    else $error("ones count exceeds logical size");

  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_status != gbe_pkg::ST_OK) |->
      (!out_read_value && out_ones_count == '0))
    else $error("error result carries data");

  a_size_cap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_logical_size <= gbe_pkg::SIZE_W'(gbe_pkg::MAX_BITS))
    else $error("logical size past capacity");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result overwritten while pending");

endmodule

@@ hdl/gbe_ctrl.sv @@
// Request sequencer: walks each request through clear, fill, read and count phases.
`timescale 1ns / 1ps

module gbe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gbe_pkg::dp_stat_t  stat,
  output gbe_pkg::dp_cmd_t   cmd
);

  gbe_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbe_pkg::S_RSTCLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      gbe_pkg::S_RSTCLR: begin
        cmd.clr_wr   = 1'b1;
        cmd.widx_inc = 1'b1;
        if (stat.widx_max) state_next = gbe_pkg::S_IDLE;
      end
      gbe_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = gbe_pkg::S_EXEC;
        end
      end
      gbe_pkg::S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = gbe_pkg::S_FIN;
        if (stat.ok) begin
          unique case (stat.req)
            gbe_pkg::REQ_INIT:      state_next = gbe_pkg::S_INITCLR;
            gbe_pkg::REQ_SET_BIT:   state_next = gbe_pkg::S_FILL;
            gbe_pkg::REQ_SET_RANGE: begin
              if (!stat.zero_len) state_next = gbe_pkg::S_FILL;
            end
            gbe_pkg::REQ_READ_BIT:  state_next = gbe_pkg::S_RDWAIT;
            gbe_pkg::REQ_COUNT:     state_next = gbe_pkg::S_CNT;
            default:                state_next = gbe_pkg::S_FIN;
          endcase
        end
      end
      gbe_pkg::S_INITCLR: begin
        cmd.clr_wr   = 1'b1;
        cmd.widx_inc = 1'b1;
        if (stat.widx_max) state_next = gbe_pkg::S_FIN;
      end
      gbe_pkg::S_FILL: begin
        cmd.fill_wr = 1'b1;
        if (stat.widx_at_hi) begin
          state_next = gbe_pkg::S_FIN;
        end else begin
          cmd.widx_inc = 1'b1;
        end
      end
      gbe_pkg::S_RDWAIT: begin
        state_next = gbe_pkg::S_RDCAP;
      end
      gbe_pkg::S_RDCAP: begin
        cmd.rd_cap = 1'b1;
        state_next = gbe_pkg::S_FIN;
      end
      gbe_pkg::S_CNT: begin
        cmd.cnt_rd = 1'b1;
        if (stat.widx_at_hi) begin
          state_next = gbe_pkg::S_CNTEND;
        end else begin
          cmd.widx_inc = 1'b1;
        end
      end
      gbe_pkg::S_CNTEND: begin
        state_next = gbe_pkg::S_FIN;
      end
      gbe_pkg::S_FIN: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = gbe_pkg::S_IDLE;
        end
      end
      default: state_next = gbe_pkg::S_RSTCLR;
    endcase
  end

endmodule

@@ hdl/gbe_dp.sv @@
// Datapath: request registers, size, word-wide bit store, masks, popcount and result register.
`timescale 1ns / 1ps

module gbe_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [gbe_pkg::REQ_W-1:0]     in_req,
  input  logic [gbe_pkg::OFF_W-1:0]     in_off,
  input  logic [gbe_pkg::OFF_W-1:0]     in_end,
  input  logic [gbe_pkg::SIZE_W-1:0]    in_len,
  input  logic                          in_wbit,
  input  gbe_pkg::dp_cmd_t              cmd,
  output gbe_pkg::dp_stat_t             stat,
  input  logic                          out_ready,
  output logic                          out_valid,
  output gbe_pkg::status_t              out_status,
  output logic                          out_read_value,
  output logic [gbe_pkg::SIZE_W-1:0]    out_ones_count,
  output logic [gbe_pkg::SIZE_W-1:0]    out_logical_size
);

  localparam int WW = gbe_pkg::WORD_W;
  localparam int XW = gbe_pkg::WIDX_W;
  localparam int BW = gbe_pkg::BIDX_W;
  localparam int OW = gbe_pkg::OFF_W;
  localparam int SW = gbe_pkg::SIZE_W;
  localparam logic [SW:0] MAX_EXT = (SW + 1)'(gbe_pkg::MAX_BITS);

  function automatic logic [WW-1:0] word_mask(input logic [XW-1:0] w,
                                               input logic [OW-1:0] lo,
                                               input logic [OW-1:0] hi);
    logic [WW-1:0] lo_m;
    logic [WW-1:0] hi_m;
    lo_m = (w == lo[OW-1:BW]) ? ({WW{1'b1}} << lo[BW-1:0]) : {WW{1'b1}};
    hi_m = (w == hi[OW-1:BW]) ? ({WW{1'b1}} >> (~hi[BW-1:0])) : {WW{1'b1}};
    return lo_m & hi_m;
  endfunction

  function automatic logic [gbe_pkg::PC_W-1:0] popcount(input logic [WW-1:0] x);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) l1[i] = {1'b0, x[2*i]} + {1'b0, x[2*i+1]};
    for (int i = 0; i < 8; i++)  l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    for (int i = 0; i < 4; i++)  l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    for (int i = 0; i < 2; i++)  l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

  logic [WW-1:0]       mem [gbe_pkg::WORDS];
  logic [WW-1:0]       rdata;

  gbe_pkg::req_t       req;
  logic [OW-1:0]       off;
  logic [OW-1:0]       end_off;
  logic [SW-1:0]       len;
  logic                wbit;
  logic [SW-1:0]       size;
  logic [XW-1:0]       widx;
  logic [XW-1:0]       pidx;
  logic                pend;
  logic [SW-1:0]       acc;
  logic                rd;
  gbe_pkg::status_t    res_status;

  logic [SW-1:0]       need_bit;
  logic [SW:0]         need_run;
  logic                cap_bit;
  logic                cap_run;
  logic                cap_init;
  logic                range_bad;
  logic                zero_len;
  gbe_pkg::status_t    st_code;
  logic [OW-1:0]       hi_bit;
  logic                we;
  logic [WW-1:0]       wmask;
  logic                wval;

  assign need_bit  = {1'b0, off} + SW'(1);
  assign need_run  = {2'b00, off} + {1'b0, len};
  assign cap_bit   = {1'b0, need_bit} > MAX_EXT;
  assign cap_run   = need_run > MAX_EXT;
  assign cap_init  = {1'b0, len} > MAX_EXT;
  assign range_bad = (off > end_off) || ({1'b0, end_off} >= size);
  assign zero_len  = (len == '0);

  always_comb begin
    st_code = gbe_pkg::ST_OK;
    hi_bit  = off;
    case (req)
      gbe_pkg::REQ_INIT: begin
        if (cap_init) st_code = gbe_pkg::ST_CAP;
      end
      gbe_pkg::REQ_SET_BIT, gbe_pkg::REQ_READ_BIT: begin
        if (cap_bit) st_code = gbe_pkg::ST_CAP;
      end
      gbe_pkg::REQ_SET_RANGE: begin
        if (!zero_len && cap_run) st_code = gbe_pkg::ST_CAP;
        hi_bit = OW'(need_run - (SW + 1)'(1));
      end
      gbe_pkg::REQ_COUNT: begin
        if (range_bad) st_code = gbe_pkg::ST_RANGE;
        hi_bit = end_off;
      end
      default: st_code = gbe_pkg::ST_OK;
    endcase
  end

  assign stat.req        = req;
  assign stat.ok         = (st_code == gbe_pkg::ST_OK);
  assign stat.zero_len   = zero_len;
  assign stat.widx_max   = (widx == XW'(gbe_pkg::WORDS - 1));
  assign stat.widx_at_hi = (widx == hi_bit[OW-1:BW]);
  assign stat.out_free   = !out_valid || out_ready;

  // store write port: full-word clear or masked fill
  assign we    = cmd.clr_wr || cmd.fill_wr;
  assign wmask = cmd.clr_wr ? {WW{1'b1}} : word_mask(widx, off, hi_bit);
  assign wval  = cmd.clr_wr ? 1'b0 : wbit;

  always_ff @(posedge clk) begin
    rdata <= mem[widx];
    for (int b = 0; b < WW; b++) begin
      if (we && wmask[b]) mem[widx][b] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size      <= '0;
      widx      <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= cmd.cnt_rd;
      if (cmd.exec) begin
        widx <= (req == gbe_pkg::REQ_INIT) ? '0 : off[OW-1:BW];
        if (st_code == gbe_pkg::ST_OK) begin
          case (req)
            gbe_pkg::REQ_INIT: size <= len;
            gbe_pkg::REQ_SET_BIT, gbe_pkg::REQ_READ_BIT: begin
              if (need_bit > size) size <= need_bit;
            end
            gbe_pkg::REQ_SET_RANGE: begin
              if (!zero_len && (need_run > {1'b0, size})) size <= need_run[SW-1:0];
            end
            default: size <= size;
          endcase
        end
      end else if (cmd.widx_inc) begin
        widx <= widx + XW'(1);
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pidx <= widx;
    if (cmd.load) begin
      req     <= gbe_pkg::req_t'(in_req);
      off     <= in_off;
      end_off <= in_end;
      len     <= in_len;
      wbit    <= in_wbit;
      acc     <= '0;
      rd      <= 1'b0;
    end else begin
      if (pend) acc <= acc + SW'(popcount(rdata & word_mask(pidx, off, end_off)));
      if (cmd.rd_cap) rd <= rdata[off[BW-1:0]];
    end
    if (cmd.exec) res_status <= st_code;
    if (cmd.out_load) begin
      out_status       <= res_status;
      out_read_value   <= rd;
      out_ones_count   <= acc;
      out_logical_size <= size;
    end
  end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the growable bitmap engine: shadow bitmap, stream drivers, checks.
`timescale 1ns / 1ps

import gbe_pkg::*;

typedef struct {
  status_t     st;
  logic        rd;
  logic [12:0] ones;
  logic [12:0] size;
} bitmap_reply_t;

class bitmap_shadow;
  bit [MAX_BITS-1:0] cells;
  int unsigned       size_bits;
  bitmap_reply_t     awaited[$];
  int                kind_seen[8];
  int                cap_seen, range_seen, checked, errors;

  function bit grow(int unsigned need);
    if (need > MAX_BITS) return 1'b0;
    for (int unsigned i = size_bits; i < need; i++) cells[i] = 1'b0;
    if (need > size_bits) size_bits = need;
    return 1'b1;
  endfunction

  function void note_request(logic [2:0] kind, logic [11:0] off, logic [11:0] endo,
                             logic [12:0] len, logic wb);
    bitmap_reply_t r;
    int unsigned   o, e, n, cnt;
    o = off;
    e = endo;
    n = len;
    cnt = 0;
    r.st = ST_OK;
    r.rd = 1'b0;
    case (kind)
      REQ_INIT: begin
        if (n > MAX_BITS) r.st = ST_CAP;
        else begin
          cells = '0;
          size_bits = n;
        end
      end
      REQ_SET_BIT: begin
        if (!grow(o + 1)) r.st = ST_CAP;
        else cells[o] = wb;
      end
      REQ_SET_RANGE: begin
        if (n != 0) begin
          if (!grow(o + n)) r.st = ST_CAP;
          else for (int unsigned i = o; i < o + n; i++) cells[i] = wb;
        end
      end
      REQ_READ_BIT: begin
        if (!grow(o + 1)) r.st = ST_CAP;
        else r.rd = cells[o];
      end
      REQ_COUNT: begin
        if (o > e || e >= size_bits) r.st = ST_RANGE;
        else for (int unsigned i = o; i <= e; i++) cnt += cells[i];
      end
      default: ;
    endcase
    r.ones = cnt[12:0];
    r.size = size_bits[12:0];
    kind_seen[kind]++;
    if (r.st == ST_CAP) cap_seen++;
    if (r.st == ST_RANGE) range_seen++;
    awaited.push_back(r);
  endfunction

  function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_reply(logic [1:0] st, logic rd, logic [12:0] ones, logic [12:0] size);
    bitmap_reply_t r;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected word, expected none, actual status %0d size %0d",
               $time, st, size);
      errors++;
      return;
    end
    r = awaited.pop_front();
    checked++;
    compare_field("status", r.st, st);
    compare_field("read_value", r.rd, rd);
    compare_field("ones_count", r.ones, ones);
    compare_field("logical_size", r.size, size);
  endfunction
endclass

module testbench;
  localparam int          RANDOM_ITEMS     = 1200;
  localparam int          LONG_HOLD_CYCLES = 300;
  localparam int          SETTLE_CYCLES    = 150;
  localparam logic [2:0]  REQ_SPARE_FIRST  = 3'(int'(REQ_COUNT) + 1);
  localparam logic [2:0]  REQ_SPARE_LAST   = 3'(7);

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [REQ_W-1:0]       s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [ST_W-1:0]        m_axis_tuser;

  bitmap_shadow shadow = new();
  bit           hold_replies = 1'b0;

  growable_bitmap_engine_top u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      shadow.check_reply(m_axis_tuser, m_axis_tdata[0], m_axis_tdata[13:1],
                         m_axis_tdata[26:14]);
  end

  // result side: random stall pattern, plus one long hold-off on request
  initial begin : receiver
    int unsigned mode, span;
    forever begin
      if (hold_replies) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        hold_replies = 1'b0;
      end else begin
        mode = $urandom_range(3);
        span = $urandom_range(1, 40);
        repeat (span) begin
          case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(1));
            2: m_axis_tready <= ($urandom_range(4) == 0);
            default: m_axis_tready <= ($urandom_range(3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_request(input logic [2:0] kind, input int unsigned off,
                              input int unsigned endo, input int unsigned len, input logic wb);
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {2'b00, wb, len[12:0], endo[11:0], off[11:0]};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    shadow.note_request(kind, off[11:0], endo[11:0], len[12:0], wb);
  endtask

  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic int unsigned pick_offset(int unsigned sz);
    int unsigned r;
    r = $urandom_range(9);
    if (r < 6 && sz != 0) return $urandom_range(sz - 1);
    if (r < 8) return (sz + $urandom_range(31) > 4095) ? 4095 : sz + $urandom_range(31);
    return $urandom_range(4095);
  endfunction

  task automatic send_random_request();
    int unsigned pick, sz, off, endo, len, span;
    logic        wb;
    logic [2:0]  kind;
    sz   = shadow.size_bits;
    pick = $urandom_range(99);
    wb   = 1'($urandom_range(1));
    off  = pick_offset(sz);
    endo = $urandom_range(4095);
    len  = $urandom_range(8191);
    if (pick < 5) begin
      kind = REQ_INIT;
      case ($urandom_range(9))
        0: len = MAX_BITS;
        1, 2: len = $urandom_range(8191);
        default: len = $urandom_range(256);
      endcase
    end else if (pick < 30) begin
      kind = REQ_SET_BIT;
    end else if (pick < 50) begin
      kind = REQ_SET_RANGE;
      case ($urandom_range(9))
        0: len = 0;
        1: len = MAX_BITS - off;
        2: len = $urandom_range(8191);
        default: len = $urandom_range(1, 32);
      endcase
    end else if (pick < 70) begin
      kind = REQ_READ_BIT;
    end else if (pick < 97) begin
      kind = REQ_COUNT;
      if (sz != 0 && $urandom_range(9) < 8) begin
        off  = $urandom_range(sz - 1);
        span = sz - 1 - off;
        if ($urandom_range(9) != 0 && span > 64) span = 64;
        endo = off + $urandom_range(span);
      end else begin
        off = $urandom_range(4095);
      end
    end else begin
      kind = 3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST));
    end
    send_request(kind, off, endo, len, wb);
  endtask

  initial begin : stimulus
    int unsigned burst_left, gap;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed corners
    send_request(REQ_COUNT, 0, 0, 0, 1'b0);          // count on an empty bitmap
    send_request(REQ_READ_BIT, 0, 0, 0, 1'b0);       // read grows size to one
    send_request(REQ_INIT, 0, 0, MAX_BITS + 1, 1'b0); // init too large
    send_request(REQ_INIT, 4095, 4095, 8191, 1'b1);
    send_request(REQ_INIT, 0, 0, MAX_BITS, 1'b0);
    send_request(REQ_SET_RANGE, 0, 0, MAX_BITS, 1'b1);
    send_request(REQ_COUNT, 0, 4095, 0, 1'b0);
    send_request(REQ_COUNT, 4095, 0, 0, 1'b0);       // start past end
    send_request(REQ_SET_RANGE, 4095, 0, 2, 1'b1);   // range past capacity
    send_request(REQ_SET_RANGE, 10, 0, 0, 1'b0);     // zero-length range
    send_request(REQ_SET_RANGE, 33, 0, 70, 1'b0);
    send_request(REQ_COUNT, 0, 127, 0, 1'b0);
    send_request(REQ_INIT, 0, 0, 0, 1'b0);
    send_request(REQ_COUNT, 0, 0, 0, 1'b0);          // end at size
    send_request(REQ_SET_BIT, 4095, 0, 0, 1'b1);
    send_request(REQ_READ_BIT, 4095, 0, 0, 1'b0);
    send_request(REQ_READ_BIT, 4094, 0, 0, 1'b0);
    send_request(REQ_SET_BIT, 4095, 0, 0, 1'b0);
    send_request(REQ_INIT, 0, 0, 16, 1'b0);
    send_request(REQ_READ_BIT, 2000, 0, 0, 1'b0);
    send_request(REQ_COUNT, 15, 2000, 0, 1'b0);
    send_request(REQ_COUNT, 0, 2001, 0, 1'b0);
    for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++)
      send_request(3'(k), 4095, 4095, 8191, 1'b1);
    drain_replies();

    // random traffic in bursts
    burst_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) hold_replies = 1'b1;
      if (n == 800) drain_replies();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_random_request();
    end
    drain_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Requests sent: init %0d, set bit %0d, range set %0d, read %0d, count %0d, spare %0d",
             shadow.kind_seen[REQ_INIT], shadow.kind_seen[REQ_SET_BIT],
             shadow.kind_seen[REQ_SET_RANGE], shadow.kind_seen[REQ_READ_BIT],
             shadow.kind_seen[REQ_COUNT],
             shadow.kind_seen[5] + shadow.kind_seen[6] + shadow.kind_seen[7]);
    $display("Words checked: %0d, with %0d capacity and %0d range rejections",
             shadow.checked, shadow.cap_seen, shadow.range_seen);
    if (shadow.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

@@ growable_bitmap_engine_top.f @@
hdl/gbe_pkg.sv
hdl/gbe_ctrl.sv
hdl/gbe_dp.sv
hdl/growable_bitmap_engine_top.sv
tb/testbench.sv
